// ===== design/vtpy_pkg.sv =====
// Types, constants and constant functions shared by the pitch/yaw pipeline.
`timescale 1ns / 1ps

package vtpy_pkg;

  localparam int CW    = 52;  // CORDIC x/y datapath width
  localparam int AW    = 36;  // angle accumulator width, radians Q32
  localparam int GUARD = 16;  // input scaling into the CORDIC datapath

  localparam logic signed [AW-1:0] PI_Q32         = 36'sd13493037704;
  localparam logic signed [AW-1:0] QUARTER_PI_Q32 = 36'sd3373259426;
  localparam logic [29:0]          RAD2DEG_Q24    = 30'd961263669;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [24:0] pitch_angle;
    logic [24:0] yaw_angle;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] acc;
  } cordic_t;

  // restoring shift-subtract division, used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32: Taylor series in Q62, then rounded to Q32
  function automatic logic [AW-1:0] atan_q32(input int i);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] k;
    if (i == 0) begin
      return QUARTER_PI_Q32;
    end
    p = 64'(1) << (62 - i);
    s = '0;
    k = '0;
    while (p != 64'd0) begin
      t = udiv64(p, (k << 1) + 64'd1);
      if (k[0]) begin
        s = s - t;
      end else begin
        s = s + t;
      end
      p = p >> (2 * i);
      k = k + 64'd1;
    end
    return AW'((s + (64'(1) << 29)) >> 30);
  endfunction

endpackage

// ===== design/vtpy_cordic_step.sv =====
// One CORDIC vectoring iteration: rotate toward b = 0 and accumulate the angle.
`timescale 1ns / 1ps

module vtpy_cordic_step #(
  parameter int                                SHIFT = 0,
  parameter logic signed [vtpy_pkg::AW-1:0]    ANGLE = '0
) (
  input  vtpy_pkg::cordic_t cur_i,
  output vtpy_pkg::cordic_t nxt_o
);

  logic signed [vtpy_pkg::CW-1:0] da;
  logic signed [vtpy_pkg::CW-1:0] db;

  assign da = cur_i.b >>> SHIFT;
  assign db = cur_i.a >>> SHIFT;

  always_comb begin
    if (!cur_i.b[vtpy_pkg::CW-1]) begin
      nxt_o.a   = cur_i.a + da;
      nxt_o.b   = cur_i.b - db;
      nxt_o.acc = cur_i.acc + ANGLE;
    end else begin
      nxt_o.a   = cur_i.a - da;
      nxt_o.b   = cur_i.b + db;
      nxt_o.acc = cur_i.acc - ANGLE;
    end
  end

endmodule

// ===== design/vector_to_pitch_yaw.sv =====
// Top level: direction vector to pitch and yaw angles, fully pipelined.
//
//   channel | valid       | stall        | request
//   --------+-------------+--------------+------------------------------
//   in      | in_valid_i  | in_stall_o   | in_req_i  (dir_x/y/z, Q16.16)
//   out     | out_valid_o | out_stall_i  | out_req_o (pitch/yaw angles)
//
// One item per cycle while the output is not stalled; stages: input register,
// squaring, sum, 32 square-root steps (yaw CORDIC runs alongside), the pitch
// CORDIC stages, and three stages of degree conversion and wrap.
// Reset clears only the stage valid bits. A stall passes back combinationally
// past full stages only, so empty stages keep filling while the output waits.
`timescale 1ns / 1ps

module vector_to_pitch_yaw #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRAC_BITS     = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vtpy_pkg::in_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vtpy_pkg::out_t  out_req_o
);

  localparam int CW  = vtpy_pkg::CW;
  localparam int AW  = vtpy_pkg::AW;
  localparam int NQ  = 32;
  localparam int PS  = 3 + NQ;
  localparam int D1  = PS + CORDIC_STAGES;
  localparam int NS  = D1 + 3;
  localparam logic [63:0] RND  = 64'(1) << (55 - FRAC_BITS);
  localparam logic [63:0] FULL = 64'(360) << FRAC_BITS;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS-1:0] rdy;

  assign rdy[NS-1] = !vld_q[NS-1] || !out_stall_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // stage 0: input register
  logic signed [31:0] x0_q, y0_q, z0_q;
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x0_q <= in_req_i.dir_x;
      y0_q <= in_req_i.dir_y;
      z0_q <= in_req_i.dir_z;
    end
  end

  // stage 1: squares, yaw CORDIC setup
  logic [31:0]          ux, uy;
  logic signed [CW-1:0] xe, ye;
  vtpy_pkg::cordic_t    y1_d;
  logic [63:0]          sx1_q, sy1_q;
  logic                 vert1_q, zpos1_q;
  logic signed [31:0]   z1_q;
  vtpy_pkg::cordic_t    y1_q;

  assign ux = x0_q[31] ? 32'(-x0_q) : 32'(x0_q);
  assign uy = y0_q[31] ? 32'(-y0_q) : 32'(y0_q);
  assign xe = CW'(x0_q);
  assign ye = CW'(y0_q);

  always_comb begin
    if (x0_q[31]) begin
      y1_d.a   = (-xe) <<< vtpy_pkg::GUARD;
      y1_d.b   = (-ye) <<< vtpy_pkg::GUARD;
      y1_d.acc = y0_q[31] ? -vtpy_pkg::PI_Q32 : vtpy_pkg::PI_Q32;
    end else begin
      y1_d.a   = xe <<< vtpy_pkg::GUARD;
      y1_d.b   = ye <<< vtpy_pkg::GUARD;
      y1_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sx1_q   <= 64'(ux) * 64'(ux);
      sy1_q   <= 64'(uy) * 64'(uy);
      vert1_q <= (x0_q == 32'sd0) && (y0_q == 32'sd0);
      zpos1_q <= (z0_q > 32'sd0);
      z1_q    <= z0_q;
      y1_q    <= y1_d;
    end
  end

  // stage 2: sum of squares
  logic [63:0]        n2_q;
  logic               vert2_q, zpos2_q;
  logic signed [31:0] z2_q;
  vtpy_pkg::cordic_t  y2_q;
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      n2_q    <= sx1_q + sy1_q;
      vert2_q <= vert1_q;
      zpos2_q <= zpos1_q;
      z2_q    <= z1_q;
      y2_q    <= y1_q;
    end
  end

  // square-root steps, yaw CORDIC alongside
  logic [63:0]        qn_q [NQ];
  logic [63:0]        qr_q [NQ];
  logic               qvert_q [NQ];
  logic               qzpos_q [NQ];
  logic signed [31:0] qz_q [NQ];
  vtpy_pkg::cordic_t  qy_q [NQ];

  for (genvar j = 0; j < NQ; j++) begin : g_q
    localparam logic [63:0] BITV = 64'(1) << (62 - 2 * j);
    logic [63:0]        n_in, r_in, t_v, n_nx, r_nx;
    logic               vert_in, zpos_in;
    logic signed [31:0] z_in;
    vtpy_pkg::cordic_t  y_in, y_nx;

    if (j == 0) begin : g_first
      assign n_in    = n2_q;
      assign r_in    = '0;
      assign vert_in = vert2_q;
      assign zpos_in = zpos2_q;
      assign z_in    = z2_q;
      assign y_in    = y2_q;
    end else begin : g_next
      assign n_in    = qn_q[j-1];
      assign r_in    = qr_q[j-1];
      assign vert_in = qvert_q[j-1];
      assign zpos_in = qzpos_q[j-1];
      assign z_in    = qz_q[j-1];
      assign y_in    = qy_q[j-1];
    end

    assign t_v = r_in + BITV;
    always_comb begin
      if (n_in >= t_v) begin
        n_nx = n_in - t_v;
        r_nx = (r_in >> 1) + BITV;
      end else begin
        n_nx = n_in;
        r_nx = r_in >> 1;
      end
    end

    if (j < CORDIC_STAGES) begin : g_cs
      vtpy_cordic_step #(
        .SHIFT(j),
        .ANGLE(vtpy_pkg::atan_q32(j))
      ) u_step (
        .cur_i(y_in),
        .nxt_o(y_nx)
      );
    end else begin : g_hold
      assign y_nx = y_in;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[3+j]) begin
        qn_q[j]    <= n_nx;
        qr_q[j]    <= r_nx;
        qvert_q[j] <= vert_in;
        qzpos_q[j] <= zpos_in;
        qz_q[j]    <= z_in;
        qy_q[j]    <= y_nx;
      end
    end
  end

  // pitch CORDIC stages
  vtpy_pkg::cordic_t    pp_q [CORDIC_STAGES];
  logic signed [AW-1:0] pyc_q [CORDIC_STAGES];
  logic                 pvert_q [CORDIC_STAGES];
  logic                 pzpos_q [CORDIC_STAGES];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_p
    vtpy_pkg::cordic_t    p_in, p_nx;
    logic signed [AW-1:0] yc_in;
    logic                 vert_in, zpos_in;

    if (k == 0) begin : g_first
      assign p_in.a   = CW'(qr_q[NQ-1]) << vtpy_pkg::GUARD;
      assign p_in.b   = -(CW'(qz_q[NQ-1]) <<< vtpy_pkg::GUARD);
      assign p_in.acc = '0;
      assign yc_in    = qy_q[NQ-1].acc;
      assign vert_in  = qvert_q[NQ-1];
      assign zpos_in  = qzpos_q[NQ-1];
    end else begin : g_next
      assign p_in    = pp_q[k-1];
      assign yc_in   = pyc_q[k-1];
      assign vert_in = pvert_q[k-1];
      assign zpos_in = pzpos_q[k-1];
    end

    vtpy_cordic_step #(
      .SHIFT(k),
      .ANGLE(vtpy_pkg::atan_q32(k))
    ) u_step (
      .cur_i(p_in),
      .nxt_o(p_nx)
    );

    always_ff @(posedge clk_i) begin
      if (rdy[PS+k]) begin
        pp_q[k]    <= p_nx;
        pyc_q[k]   <= yc_in;
        pvert_q[k] <= vert_in;
        pzpos_q[k] <= zpos_in;
      end
    end
  end

  // degree conversion: partial products
  logic signed [AW-1:0] pacc, yacc;
  logic [AW-1:0]        pm, ym;
  logic [47:0]          plo1_q, phi1_q, ylo1_q, yhi1_q;
  logic                 pneg1_q, yneg1_q, vert3_q, zpos3_q;

  assign pacc = pp_q[CORDIC_STAGES-1].acc;
  assign yacc = pyc_q[CORDIC_STAGES-1];
  assign pm   = pacc[AW-1] ? AW'(-pacc) : AW'(pacc);
  assign ym   = yacc[AW-1] ? AW'(-yacc) : AW'(yacc);

  always_ff @(posedge clk_i) begin
    if (rdy[D1]) begin
      plo1_q  <= 48'(pm[17:0]) * 48'(vtpy_pkg::RAD2DEG_Q24);
      phi1_q  <= 48'(pm[AW-1:18]) * 48'(vtpy_pkg::RAD2DEG_Q24);
      ylo1_q  <= 48'(ym[17:0]) * 48'(vtpy_pkg::RAD2DEG_Q24);
      yhi1_q  <= 48'(ym[AW-1:18]) * 48'(vtpy_pkg::RAD2DEG_Q24);
      pneg1_q <= pacc[AW-1];
      yneg1_q <= yacc[AW-1];
      vert3_q <= pvert_q[CORDIC_STAGES-1];
      zpos3_q <= pzpos_q[CORDIC_STAGES-1];
    end
  end

  // product sum plus rounding
  logic [63:0] ps2_q, ys2_q;
  logic        pneg2_q, yneg2_q, vert4_q, zpos4_q;
  always_ff @(posedge clk_i) begin
    if (rdy[D1+1]) begin
      ps2_q   <= 64'(plo1_q) + (64'(phi1_q) << 18) + RND;
      ys2_q   <= 64'(ylo1_q) + (64'(yhi1_q) << 18) + RND;
      pneg2_q <= pneg1_q;
      yneg2_q <= yneg1_q;
      vert4_q <= vert3_q;
      zpos4_q <= zpos3_q;
    end
  end

  function automatic logic [24:0] wrap_deg(input logic [63:0] s, input logic neg);
    logic [63:0] d;
    d = s >> (56 - FRAC_BITS);
    if (neg) begin
      d = (d >= FULL) ? 64'd0 : FULL - d;
    end
    if (d >= FULL) begin
      d = d - FULL;
    end
    return d[24:0];
  endfunction

  // output register
  vtpy_pkg::out_t out_d, out_q;
  always_comb begin
    if (vert4_q) begin
      out_d.yaw_angle   = '0;
      out_d.pitch_angle = zpos4_q ? 25'(64'(270) << FRAC_BITS)
                                  : 25'(64'(90) << FRAC_BITS);
    end else begin
      out_d.yaw_angle   = wrap_deg(ys2_q, yneg2_q);
      out_d.pitch_angle = wrap_deg(ps2_q, pneg2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_req_o = out_q;

endmodule
